// ===== hw/rtl/b64u_pkg.sv =====
// shared types, constants and the sextet alphabet for the base64url encoder
// no dependencies
`timescale 1ns / 1ps

package b64u_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int LIMIT_WIDTH = 16;
   localparam int SYM_WIDTH   = 7;
   localparam int CMD_DEPTH   = 4;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);

   localparam logic [1:0] MODE_DATA     = 2'd0;
   localparam logic [1:0] MODE_DATA_END = 2'd1;
   localparam logic [1:0] MODE_END      = 2'd2;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = {LIMIT_WIDTH{1'b1}};

   // one queued command: one or two results for the back end
   typedef struct packed {
      logic [SYM_WIDTH-1:0]   sym0;
      logic [SYM_WIDTH-1:0]   sym1;
      logic                   two;
      logic                   sym_valid;
      logic                   last;
      logic                   error;
      logic [COUNT_WIDTH-1:0] count;
   } b64u_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } b64u_fifo_status_type;

   function automatic logic [SYM_WIDTH-1:0] sextet_char(input logic [5:0] v);
      logic [SYM_WIDTH-1:0] c;
      if (v < 6'd26) begin
         c = SYM_WIDTH'(7'h41 + {1'b0, v});
      end else if (v < 6'd52) begin
         c = SYM_WIDTH'(7'h61 + {1'b0, v} - 7'd26);
      end else if (v < 6'd62) begin
         c = SYM_WIDTH'(7'h30 + {1'b0, v} - 7'd52);
      end else if (v == 6'd62) begin
         c = 7'h2d;
      end else begin
         c = 7'h5f;
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/b64u_front.sv =====
// front end: accepts requests, packs bits into sextets, checks the output limit
// depends on b64u_pkg
`timescale 1ns / 1ps

module b64u_front
   import b64u_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_mode,
   input  logic [7:0]             req_data_byte,
   input  logic                   csr_wr_en,
   input  logic [LIMIT_WIDTH-1:0] csr_wr_data,
   input  b64u_fifo_status_type   fifo_status,
   output logic                   push,
   output b64u_cmd_type           push_cmd
);

   localparam logic [1:0] LC_ZERO = 2'd0;
   localparam logic [1:0] LC_TWO  = 2'd1;
   localparam logic [1:0] LC_FOUR = 2'd2;

   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;
   logic [3:0]             lb_ff, lb_in;
   logic [1:0]             lc_ff, lc_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   abort_ff, abort_in;

   logic                   accept;
   logic                   has_byte;
   logic                   ending;
   logic [5:0]             s0, s1;
   logic [1:0]             n;
   logic [3:0]             lb_step;
   logic [1:0]             lc_step;
   logic [1:0]             need;
   logic [COUNT_WIDTH:0]   sum_need;
   logic [COUNT_WIDTH:0]   sum_n;
   logic                   over;
   logic [7:0]             b;

   assign req_ready = !fifo_status.full;
   assign accept    = req_valid && req_ready;
   assign b         = req_data_byte;
   assign has_byte  = (req_mode == MODE_DATA) || (req_mode == MODE_DATA_END);
   assign ending    = (req_mode != MODE_DATA);

   always_comb begin
      s0      = '0;
      s1      = '0;
      n       = 2'd0;
      lb_step = lb_ff;
      lc_step = lc_ff;
      case (lc_ff)
         LC_ZERO: begin
            if (has_byte) begin
               s0      = b[7:2];
               n       = 2'd1;
               lb_step = {2'b00, b[1:0]};
               lc_step = LC_TWO;
               if (ending) begin
                  s1 = {b[1:0], 4'b0000};
                  n  = 2'd2;
               end
            end
         end
         LC_TWO: begin
            if (has_byte) begin
               s0      = {lb_ff[1:0], b[7:4]};
               n       = 2'd1;
               lb_step = b[3:0];
               lc_step = LC_FOUR;
               if (ending) begin
                  s1 = {b[3:0], 2'b00};
                  n  = 2'd2;
               end
            end else begin
               s0 = {lb_ff[1:0], 4'b0000};
               n  = 2'd1;
            end
         end
         default: begin
            if (has_byte) begin
               s0      = {lb_ff, b[7:6]};
               s1      = b[5:0];
               n       = 2'd2;
               lb_step = 4'd0;
               lc_step = LC_ZERO;
            end else begin
               s0 = {lb_ff, 2'b00};
               n  = 2'd1;
            end
         end
      endcase
   end

   assign need     = n + {1'b0, ending};
   assign sum_need = {1'b0, cnt_ff} + (COUNT_WIDTH+1)'(need);
   assign sum_n    = {1'b0, cnt_ff} + (COUNT_WIDTH+1)'(n);
   assign over     = (sum_need > (COUNT_WIDTH+1)'(limit_ff)) || sum_n[COUNT_WIDTH];

   always_comb begin
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
      lb_in    = lb_ff;
      lc_in    = lc_ff;
      cnt_in   = cnt_ff;
      abort_in = abort_ff;
      push     = 1'b0;
      push_cmd.sym0      = sextet_char(s0);
      push_cmd.sym1      = sextet_char(s1);
      push_cmd.two       = (n == 2'd2);
      push_cmd.sym_valid = 1'b1;
      push_cmd.last      = ending;
      push_cmd.error     = 1'b0;
      push_cmd.count     = cnt_ff + COUNT_WIDTH'(1);
      if (accept) begin
         if (abort_ff) begin
            if (ending) begin
               lb_in    = '0;
               lc_in    = LC_ZERO;
               cnt_in   = '0;
               abort_in = 1'b0;
            end
         end else begin
            push = 1'b1;
            if (over) begin
               push_cmd.sym0      = '0;
               push_cmd.two       = 1'b0;
               push_cmd.sym_valid = 1'b0;
               push_cmd.last      = 1'b1;
               push_cmd.error     = 1'b1;
               push_cmd.count     = cnt_ff;
               abort_in           = !ending;
            end else if (n == 2'd0) begin
               push_cmd.sym0      = '0;
               push_cmd.sym_valid = 1'b0;
               push_cmd.count     = cnt_ff;
            end
            if (ending) begin
               lb_in  = '0;
               lc_in  = LC_ZERO;
               cnt_in = '0;
            end else if (!over) begin
               lb_in  = lb_step;
               lc_in  = lc_step;
               cnt_in = sum_n[COUNT_WIDTH-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         lb_ff    <= '0;
         lc_ff    <= LC_ZERO;
         cnt_ff   <= '0;
         abort_ff <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         lb_ff    <= lb_in;
         lc_ff    <= lc_in;
         cnt_ff   <= cnt_in;
         abort_ff <= abort_in;
      end
   end

endmodule

// ===== hw/rtl/b64u_cmd_fifo.sv =====
// small command queue between the front end and the back end
// depends on b64u_pkg
`timescale 1ns / 1ps

module b64u_cmd_fifo
   import b64u_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64u_cmd_type         push_cmd,
   input  logic                 pop,
   output b64u_cmd_type         head,
   output b64u_fifo_status_type status
);

   b64u_cmd_type           mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_W:0]     fill_ff, fill_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = (fill_ff == (CMD_PTR_W+1)'(CMD_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + CMD_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (CMD_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (CMD_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== hw/rtl/b64u_back.sv =====
// back end: expands queued commands into results and holds the output register
// depends on b64u_pkg
`timescale 1ns / 1ps

module b64u_back
   import b64u_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  b64u_cmd_type           head,
   input  b64u_fifo_status_type   fifo_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SYM_WIDTH-1:0]   rsp_symbol,
   output logic                   rsp_symbol_valid,
   output logic                   rsp_last,
   output logic                   rsp_error,
   output logic [COUNT_WIDTH-1:0] rsp_char_count
);

   logic                   valid_ff, valid_in;
   logic                   phase_ff, phase_in;
   logic [SYM_WIDTH-1:0]   sym_ff, sym_in;
   logic                   symv_ff, symv_in;
   logic                   last_ff, last_in;
   logic                   err_ff, err_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   load;
   logic                   final_part;

   assign load       = (!valid_ff || rsp_ready) && !fifo_status.empty;
   assign final_part = phase_ff || !head.two;
   assign pop        = load && final_part;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      phase_in = phase_ff;
      sym_in   = sym_ff;
      symv_in  = symv_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = !final_part;
         sym_in   = phase_ff ? head.sym1 : head.sym0;
         symv_in  = head.sym_valid;
         last_in  = head.last && final_part;
         err_in   = head.error;
         cnt_in   = head.count + COUNT_WIDTH'(phase_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      symv_ff <= symv_in;
      last_ff <= last_in;
      err_ff  <= err_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_symbol       = sym_ff;
   assign rsp_symbol_valid = symv_ff;
   assign rsp_last         = last_ff;
   assign rsp_error        = err_ff;
   assign rsp_char_count   = cnt_ff;

endmodule

// ===== hw/rtl/base64url_stream_encoder_top.sv =====
// top level of the unpadded base64url stream encoder
// depends on b64u_pkg, b64u_front, b64u_cmd_fifo, b64u_back
`timescale 1ns / 1ps
//
// usage
// request channel (req_valid/req_ready): one byte per request with a mode:
//   data, data ending the message, or an end with no byte that flushes the tail
// response channel (rsp_valid/rsp_ready): one character per response, or a
//   single marker response with symbol_valid low at an empty end or on error
// csr_wr_en/csr_wr_data set the output limit (terminator position included);
//   write it only while no message is in flight
// path: an accepted request is written into the command queue, then the back
//   end loads its first response into the response register; a second
//   character is loaded once the first has been taken
// throughput: one request per cycle enters a four-entry command queue while it
//   is not full; the response register drains one response per cycle while
//   rsp_ready is high, so a request that makes two characters holds the back
//   end for both of them (4/3 characters per byte on average)
// reset clears the message state, the queue and the response valid flag and
//   sets the limit to 65535
// a stalled receiver holds the current response; the queue keeps taking
//   requests until it fills, then req_ready drops
//

module base64url_stream_encoder_top
   import b64u_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_mode,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SYM_WIDTH-1:0]   rsp_symbol,
   output logic                   rsp_symbol_valid,
   output logic                   rsp_last,
   output logic                   rsp_error,
   output logic [COUNT_WIDTH-1:0] rsp_char_count,
   input  logic                   csr_wr_en,
   input  logic [LIMIT_WIDTH-1:0] csr_wr_data
);

   b64u_fifo_status_type fifo_status;
   b64u_cmd_type         push_cmd;
   b64u_cmd_type         head;
   logic                 push;
   logic                 pop;

   b64u_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fifo_status   (fifo_status),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   b64u_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (fifo_status)
   );

   b64u_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .fifo_status      (fifo_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_symbol_valid (rsp_symbol_valid),
      .rsp_last         (rsp_last),
      .rsp_error        (rsp_error),
      .rsp_char_count   (rsp_char_count)
   );

   // error marker always closes the message and carries no character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && !rsp_symbol_valid)
      else $error("error response without last or with a character");

   // marker responses only end a message
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_symbol_valid |-> rsp_last)
      else $error("marker response not marked last");

   // consecutive characters of one message count up by one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_symbol_valid && !rsp_last
         ##1 rsp_valid && rsp_symbol_valid)
      |-> rsp_char_count == $past(rsp_char_count) + COUNT_WIDTH'(1))
      else $error("character count did not step by one");

   // the queue cannot be full and empty at once
   assert property (@(posedge clock) disable iff (reset)
      !(fifo_status.full && fifo_status.empty))
      else $error("command queue full and empty together");

endmodule

// ===== bench/tb_base64url_stream_encoder_top.sv =====
// self-checking bench for the unpadded base64url stream encoder: a directed request table,
// then random messages under several output limits, checked against an in-bench encoder
// depends on b64u_pkg and base64url_stream_encoder_top
`timescale 1ns / 1ps

module tb_base64url_stream_encoder_top;
   import b64u_pkg::*;

   localparam logic [1:0] MODE_END_ALT = 2'd3;
   localparam int         COUNT_MAX    = (1 << COUNT_WIDTH) - 1;
   localparam logic [0:63][7:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

   typedef struct packed {
      logic [SYM_WIDTH-1:0]   symbol;
      logic                   symbol_valid;
      logic                   last;
      logic                   error;
      logic [COUNT_WIDTH-1:0] char_count;
   } char_rsp_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [1:0]             mode;
      logic [7:0]             data;
      logic                   typed;
      char_rsp_type           want;
      logic [LIMIT_WIDTH-1:0] limit;
   } dir_row_type;

   localparam char_rsp_type NO_WANT    = '0;
   localparam char_rsp_type EMPTY_END  = '{7'd0, 1'b0, 1'b1, 1'b0, 16'd0};
   localparam char_rsp_type OVER_LIMIT = '{7'd0, 1'b0, 1'b1, 1'b1, 16'd0};

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_mode;
   logic [7:0]             req_data_byte;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [SYM_WIDTH-1:0]   rsp_symbol;
   logic                   rsp_symbol_valid;
   logic                   rsp_last;
   logic                   rsp_error;
   logic [COUNT_WIDTH-1:0] rsp_char_count;
   logic                   csr_wr_en;
   logic [LIMIT_WIDTH-1:0] csr_wr_data;

   // encoder shadow state
   logic [3:0]             tail_bits;
   logic [2:0]             tail_len;
   logic [COUNT_WIDTH-1:0] msg_count;
   logic                   msg_dropped;
   logic [LIMIT_WIDTH-1:0] limit_shadow;

   char_rsp_type pending_chars [$];
   int           mismatches;
   int           rsp_seen;
   bit           quiet;

   dir_row_type dir_rows [0:28] = '{
      '{ROW_REQ, MODE_END,      8'h00, 1'b1, EMPTY_END,  16'd0},
      '{ROW_REQ, MODE_END_ALT,  8'hff, 1'b1, EMPTY_END,  16'd0},
      '{ROW_REQ, MODE_DATA_END, 8'h00, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_DATA,     8'hff, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_DATA,     8'hff, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_DATA_END, 8'hff, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_DATA,     8'hfb, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_DATA,     8'hef, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_DATA_END, 8'hbe, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_DATA,     8'h80, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_END,      8'ha5, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_DATA,     8'h7f, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_DATA,     8'h01, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_END_ALT,  8'h00, 1'b0, NO_WANT,    16'd0},
      '{ROW_CSR, MODE_DATA,     8'h00, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_END,      8'h00, 1'b1, OVER_LIMIT, 16'd0},
      '{ROW_REQ, MODE_DATA,     8'h12, 1'b1, OVER_LIMIT, 16'd0},
      '{ROW_REQ, MODE_DATA,     8'h34, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_DATA_END, 8'h56, 1'b0, NO_WANT,    16'd0},
      '{ROW_CSR, MODE_DATA,     8'h00, 1'b0, NO_WANT,    16'd1},
      '{ROW_REQ, MODE_END,      8'h00, 1'b1, EMPTY_END,  16'd0},
      '{ROW_REQ, MODE_DATA,     8'h00, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_END,      8'h00, 1'b0, NO_WANT,    16'd0},
      '{ROW_CSR, MODE_DATA,     8'h00, 1'b0, NO_WANT,    16'd3},
      '{ROW_REQ, MODE_DATA,     8'h3c, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_DATA_END, 8'hc3, 1'b0, NO_WANT,    16'd0},
      '{ROW_CSR, MODE_DATA,     8'h00, 1'b0, NO_WANT,    16'hffff},
      '{ROW_REQ, MODE_DATA,     8'h00, 1'b0, NO_WANT,    16'd0},
      '{ROW_REQ, MODE_DATA_END, 8'hff, 1'b0, NO_WANT,    16'd0}
   };

   base64url_stream_encoder_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_symbol_valid (rsp_symbol_valid),
      .rsp_last         (rsp_last),
      .rsp_error        (rsp_error),
      .rsp_char_count   (rsp_char_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #8_000_000;
      $display("base64url_stream_encoder_top regression: fail");
      $finish;
   end

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   function automatic void clear_message();
      tail_bits   = '0;
      tail_len    = '0;
      msg_count   = '0;
      msg_dropped = 1'b0;
   endfunction

   // returns how many responses one request makes and fills them in
   function automatic int encode_request(input logic [1:0] mode, input logic [7:0] b,
                                         output char_rsp_type res [2]);
      logic        has_byte;
      logic        ending;
      logic [11:0] acc;
      logic [5:0]  sext [3];
      int          shift;
      int          n;
      int          cnt;
      int          need;
      res[0]   = '0;
      res[1]   = '0;
      has_byte = (mode == MODE_DATA) || (mode == MODE_DATA_END);
      ending   = (mode != MODE_DATA);
      if (msg_dropped) begin
         if (ending) clear_message();
         return 0;
      end
      shift = (tail_len > 3'd4) ? 4 : int'(tail_len);
      acc   = 12'(tail_bits) & ((12'd1 << shift) - 12'd1);
      n     = 0;
      if (has_byte) begin
         acc   = {acc[3:0], b};
         shift = shift + 8;
         while (shift >= 6) begin
            sext[n] = 6'(acc >> (shift - 6));
            n++;
            shift = shift - 6;
         end
         acc = acc & ((12'd1 << shift) - 12'd1);
      end
      if (ending && shift > 0) begin
         sext[n] = 6'(acc << (6 - shift));
         n++;
         shift = 0;
         acc   = '0;
      end
      cnt  = int'(msg_count);
      need = n + (ending ? 1 : 0);
      if (cnt + need > int'(limit_shadow) || cnt + n > COUNT_MAX) begin
         res[0] = '{7'd0, 1'b0, 1'b1, 1'b1, COUNT_WIDTH'(cnt)};
         if (ending) clear_message();
         else msg_dropped = 1'b1;
         return 1;
      end
      for (int k = 0; k < n; k++) begin
         cnt++;
         res[k] = '{ALPHABET[sext[k]][SYM_WIDTH-1:0], 1'b1, ending && (k == n - 1), 1'b0,
                    COUNT_WIDTH'(cnt)};
      end
      if (ending) begin
         if (n == 0) begin
            res[0] = '{7'd0, 1'b0, 1'b1, 1'b0, COUNT_WIDTH'(cnt)};
            n      = 1;
         end
         clear_message();
      end else begin
         tail_bits = acc[3:0];
         tail_len  = 3'(shift);
         msg_count = COUNT_WIDTH'(cnt);
      end
      return n;
   endfunction

   task automatic send(input logic [1:0] mode, input logic [7:0] b, input logic typed,
                       input char_rsp_type want);
      char_rsp_type res [2];
      int           gap;
      int           n;
      gap = quiet ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_mode      = mode;
      req_data_byte = b;
      do @(posedge clock); while (!req_ready);
      n = encode_request(mode, b, res);
      if (typed) begin
         pending_chars.push_back(want);
      end else begin
         for (int k = 0; k < n; k++) pending_chars.push_back(res[k]);
      end
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      // requests dropped after an error make no response and are never queued
      repeat (10) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_WIDTH-1:0] value);
      wait_for_drain();
      @(negedge clock);
      csr_wr_en    = 1'b1;
      csr_wr_data  = value;
      limit_shadow = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic run_phase(input logic [LIMIT_WIDTH-1:0] limit, input int items,
                            input bit burst, input bit pause_mid);
      int  sent;
      int  len;
      int  style;
      bit  paused;
      logic [1:0] mode;
      write_limit(limit);
      quiet  = burst;
      sent   = 0;
      paused = 1'b0;
      while (sent < items) begin
         len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 10);
         style = $urandom_range(0, 9);
         if (style < 8) begin
            // well-formed message, ended by its last byte or by an end request
            for (int i = 0; i < len; i++) begin
               mode = (i == len - 1 && style < 5) ? MODE_DATA_END : MODE_DATA;
               send(mode, 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
            end
            if (len == 0 || style >= 5) begin
               mode = (style == 7) ? MODE_END_ALT : MODE_END;
               send(mode, 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
               sent++;
            end
         end else begin
            for (int i = 0; i < len; i++)
               send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
         end
         sent += len;
         if (pause_mid && !paused && sent >= items / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end
      end
      // close any open message before the next limit change
      send(MODE_END, 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
      quiet = 1'b0;
   endtask

   // response side: random stalls plus two long hold-offs
   initial begin
      char_rsp_type got;
      char_rsp_type want;
      int           gap;
      rsp_ready = 1'b0;
      rsp_seen  = 0;
      @(negedge reset);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 5);
         if (rsp_seen == 200 || rsp_seen == 1000) gap = 120;
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = '{rsp_symbol, rsp_symbol_valid, rsp_last, rsp_error, rsp_char_count};
         rsp_seen++;
         if (pending_chars.size() == 0) begin
            report($sformatf("response %0d with nothing pending: %h", rsp_seen, got));
         end else begin
            want = pending_chars.pop_front();
            if (got.symbol !== want.symbol)
               report($sformatf("rsp %0d symbol %h want %h", rsp_seen, got.symbol,
                                want.symbol));
            if (got.symbol_valid !== want.symbol_valid)
               report($sformatf("rsp %0d symbol_valid %b want %b", rsp_seen,
                                got.symbol_valid, want.symbol_valid));
            if (got.last !== want.last)
               report($sformatf("rsp %0d last %b want %b", rsp_seen, got.last, want.last));
            if (got.error !== want.error)
               report($sformatf("rsp %0d error %b want %b", rsp_seen, got.error, want.error));
            if (got.char_count !== want.char_count)
               report($sformatf("rsp %0d char_count %0d want %0d", rsp_seen,
                                got.char_count, want.char_count));
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = MODE_DATA;
      req_data_byte = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      quiet         = 1'b0;
      mismatches    = 0;
      limit_shadow  = LIMIT_RESET;
      clear_message();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            write_limit(dir_rows[i].limit);
         end else begin
            send(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      run_phase(16'hffff, 300, 1'b0, 1'b0);
      run_phase(16'd0, 120, 1'b0, 1'b0);
      run_phase(16'd1, 120, 1'b0, 1'b0);
      run_phase(16'($urandom_range(2, 12)), 300, 1'b0, 1'b1);
      run_phase(16'($urandom_range(13, 80)), 300, 1'b1, 1'b0);
      run_phase(16'($urandom_range(2, 12)), 300, 1'b0, 1'b0);
      run_phase(16'hffff, 300, 1'b1, 1'b0);
      run_phase(16'($urandom_range(0, 65535)), 150, 1'b0, 1'b0);

      wait_for_drain();
      if (mismatches == 0) begin
         $display("base64url_stream_encoder_top regression: pass");
      end else begin
         $display("base64url_stream_encoder_top regression: fail");
      end
      $finish;
   end

endmodule
